### design/tlsvs_pkg.sv
// Shared types and constants for the TLS server hello version scanner.
// Holds the word structs, the configuration set, the parse phases and codes.
// No dependencies.
`default_nettype none

package tlsvs_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] total_len;
    logic        last;
  } msg_t;

  typedef enum logic [1:0] {
    VERDICT_READ   = 2'd0,
    VERDICT_BOUNDS = 2'd1,
    VERDICT_ABSENT = 2'd2
  } verdict_t;

  typedef struct packed {
    logic     supported;
    verdict_t verdict;
  } res_t;

  typedef enum logic [1:0] {
    REG_SESSION_LEN_OFFSET = 2'd0,
    REG_FIXED_SKIP         = 2'd1,
    REG_WANTED_EXT_TYPE    = 2'd2,
    REG_WANTED_VERSION     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0]  session_len_offset;
    logic [7:0]  fixed_skip;
    logic [15:0] wanted_ext_type;
    logic [15:0] wanted_version;
  } cfg_t;

  localparam logic [7:0]  RstSessionLenOffset = 8'd43;
  localparam logic [7:0]  RstFixedSkip        = 8'd10;
  localparam logic [15:0] RstWantedExtType    = 16'd43;
  localparam logic [15:0] RstWantedVersion    = 16'h0304;

  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned ExtHeaderBytes = 4;
  localparam int unsigned VersionBytes = 2;

  typedef enum logic [11:0] {
    PH_HEAD    = 12'b0000_0000_0001,
    PH_SKIP    = 12'b0000_0000_0010,
    PH_XLEN_HI = 12'b0000_0000_0100,
    PH_XLEN_LO = 12'b0000_0000_1000,
    PH_TYPE_HI = 12'b0000_0001_0000,
    PH_TYPE_LO = 12'b0000_0010_0000,
    PH_ELEN_HI = 12'b0000_0100_0000,
    PH_ELEN_LO = 12'b0000_1000_0000,
    PH_BODY    = 12'b0001_0000_0000,
    PH_VER_HI  = 12'b0010_0000_0000,
    PH_VER_LO  = 12'b0100_0000_0000,
    PH_IDLE    = 12'b1000_0000_0000
  } phase_t;

endpackage

`default_nettype wire

### design/tlsvs_parse.sv
// Per-byte parser state and next-state logic for the version scanner.
// Decides at most one result per message on the byte that settles it.
// Depends on tlsvs_pkg.
`default_nettype none

module tlsvs_parse
  import tlsvs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire msg_t msg,
  input  wire cfg_t cfg,
  output logic      emit,
  output res_t      result
);

  phase_t      phase, phase_next;
  logic [15:0] byte_pos, byte_pos_next;
  logic [15:0] field_count, field_count_next;
  logic [16:0] ext_limit, ext_limit_next;
  logic [7:0]  high_byte, high_byte_next;
  logic [15:0] ext_kind, ext_kind_next;

  logic [15:0] pair;
  logic [16:0] total;
  logic [16:0] head_end;
  logic [16:0] block_end;
  logic [16:0] lim_hdr;
  logic [16:0] lim_rest;
  logic [15:0] count_dec;
  logic [15:0] head_skip;

  assign pair      = {high_byte, msg.data_byte};
  assign total     = {1'b0, msg.total_len};
  assign head_end  = 17'(cfg.session_len_offset) + 17'(msg.data_byte)
                   + 17'(cfg.fixed_skip) + 17'd3;
  assign head_skip = 16'(msg.data_byte) + 16'(cfg.fixed_skip);
  assign block_end = ext_limit + {1'b0, pair};
  assign lim_hdr   = ext_limit - 17'(ExtHeaderBytes);
  assign lim_rest  = lim_hdr - {1'b0, pair};
  assign count_dec = field_count - 16'd1;

  always_comb begin
    phase_next       = phase;
    byte_pos_next    = byte_pos;
    field_count_next = field_count;
    ext_limit_next   = ext_limit;
    high_byte_next   = high_byte;
    ext_kind_next    = ext_kind;
    emit             = 1'b0;
    result.supported = 1'b0;
    result.verdict   = VERDICT_READ;

    unique case (phase)
      PH_HEAD: begin
        if (byte_pos != {8'd0, cfg.session_len_offset}) begin
          if (byte_pos != 16'hFFFF) begin
            byte_pos_next = byte_pos + 16'd1;
          end
        end else begin
          ext_limit_next = head_end;
          if (head_end > total) begin
            emit           = 1'b1;
            result.verdict = VERDICT_BOUNDS;
          end else begin
            field_count_next = head_skip;
            phase_next       = (head_skip != 16'd0) ? PH_SKIP : PH_XLEN_HI;
          end
        end
      end
      PH_SKIP: begin
        field_count_next = count_dec;
        if (count_dec == 16'd0) begin
          phase_next = PH_XLEN_HI;
        end
      end
      PH_XLEN_HI: begin
        high_byte_next = msg.data_byte;
        phase_next     = PH_XLEN_LO;
      end
      PH_TYPE_HI: begin
        high_byte_next = msg.data_byte;
        phase_next     = PH_TYPE_LO;
      end
      PH_ELEN_HI: begin
        high_byte_next = msg.data_byte;
        phase_next     = PH_ELEN_LO;
      end
      PH_VER_HI: begin
        high_byte_next = msg.data_byte;
        phase_next     = PH_VER_LO;
      end
      PH_XLEN_LO: begin
        if (block_end > total) begin
          emit           = 1'b1;
          result.verdict = VERDICT_BOUNDS;
        end else begin
          ext_limit_next = {1'b0, pair};
          if (pair < 16'(ExtHeaderBytes)) begin
            emit           = 1'b1;
            result.verdict = VERDICT_ABSENT;
          end else begin
            phase_next = PH_TYPE_HI;
          end
        end
      end
      PH_TYPE_LO: begin
        ext_kind_next = pair;
        phase_next    = PH_ELEN_HI;
      end
      PH_ELEN_LO: begin
        ext_limit_next = lim_hdr;
        if ({1'b0, pair} > lim_hdr) begin
          emit           = 1'b1;
          result.verdict = VERDICT_BOUNDS;
        end else if (ext_kind == cfg.wanted_ext_type && pair == 16'(VersionBytes)) begin
          phase_next = PH_VER_HI;
        end else begin
          ext_limit_next = lim_rest;
          if (pair != 16'd0) begin
            field_count_next = pair;
            phase_next       = PH_BODY;
          end else if (lim_rest < 17'(ExtHeaderBytes)) begin
            emit           = 1'b1;
            result.verdict = VERDICT_ABSENT;
          end else begin
            phase_next = PH_TYPE_HI;
          end
        end
      end
      PH_BODY: begin
        field_count_next = count_dec;
        if (count_dec == 16'd0) begin
          if (ext_limit < 17'(ExtHeaderBytes)) begin
            emit           = 1'b1;
            result.verdict = VERDICT_ABSENT;
          end else begin
            phase_next = PH_TYPE_HI;
          end
        end
      end
      PH_VER_LO: begin
        emit             = 1'b1;
        result.verdict   = VERDICT_READ;
        result.supported = (pair == cfg.wanted_version);
      end
      PH_IDLE: begin
      end
      default: begin
      end
    endcase

    if (phase != PH_IDLE && !emit && msg.last) begin
      emit             = 1'b1;
      result.verdict   = VERDICT_BOUNDS;
      result.supported = 1'b0;
    end

    if (emit) begin
      phase_next = PH_IDLE;
    end

    if (msg.last) begin
      phase_next       = PH_HEAD;
      byte_pos_next    = '0;
      field_count_next = '0;
      ext_limit_next   = '0;
      high_byte_next   = '0;
      ext_kind_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEAD;
      byte_pos    <= '0;
      field_count <= '0;
      ext_limit   <= '0;
      high_byte   <= '0;
      ext_kind    <= '0;
    end else if (step) begin
      phase       <= phase_next;
      byte_pos    <= byte_pos_next;
      field_count <= field_count_next;
      ext_limit   <= ext_limit_next;
      high_byte   <= high_byte_next;
      ext_kind    <= ext_kind_next;
    end
  end

endmodule

`default_nettype wire

### design/tls_hello_version_scan.sv
// Top level of the TLS server hello supported versions scanner.
// Holds the configuration registers and the result register.
// Depends on tlsvs_pkg and tlsvs_parse.
//
//   channel   handshake              word     direction
//   msg       msg_valid/msg_ready    msg_t    in, one message byte
//   res       res_valid/res_ready    res_t    out, one per message
//   cfg       cfg_we                 16 bits  in, cfg_index selects register
//
// Each byte is parsed in the cycle it is accepted; a result appears in the
// result register in the following cycle. A byte is taken every cycle while the result
// register is empty or being drained, so the rate is one byte per cycle.
// A held result stalls input only when res_ready is low.
// Synchronous reset restores the configuration defaults and the parse state.
`default_nettype none

module tls_hello_version_scan
  import tlsvs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   msg_valid,
  output logic                        msg_ready,
  input  wire msg_t                   msg,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output res_t                        res,
  input  wire logic                   cfg_we,
  input  wire reg_index_t             cfg_index,
  input  wire logic [CfgDataBits-1:0] cfg_data
);

  cfg_t cfg;
  logic step;
  logic emit;
  res_t result;

  assign msg_ready = !res_valid || res_ready;
  assign step      = msg_valid && msg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.session_len_offset <= RstSessionLenOffset;
      cfg.fixed_skip         <= RstFixedSkip;
      cfg.wanted_ext_type    <= RstWantedExtType;
      cfg.wanted_version     <= RstWantedVersion;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SESSION_LEN_OFFSET: cfg.session_len_offset <= cfg_data[7:0];
        REG_FIXED_SKIP:         cfg.fixed_skip         <= cfg_data[7:0];
        REG_WANTED_EXT_TYPE:    cfg.wanted_ext_type    <= cfg_data;
        REG_WANTED_VERSION:     cfg.wanted_version     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tlsvs_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .msg    (msg),
    .cfg    (cfg),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res <= result;
    end
  end

endmodule

`default_nettype wire
